// ===== hw/rtl/cdad_pkg.sv =====
// shared types, constants and the month length table for the date adder
// no dependencies
`timescale 1ns / 1ps

package cdad_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int ADD_W   = 20;
   // day count plus the folded day of month (at most 30 more)
   localparam int CNT_W   = ADD_W + 1;
   localparam int QUOT_W  = 8;
   localparam int REM_W   = 7;
   localparam int YLEN_W  = 9;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [YLEN_W-1:0]  YEAR_DAYS = 9'd365;
   localparam logic [REM_W-1:0]   CENTURY_LAST = 7'd99;
   // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT for every 14-bit y
   localparam logic [12:0]        DIV100_MUL   = 13'd5243;
   localparam int                 DIV100_SHIFT = 19;
   localparam logic [6:0]         CENTURY      = 7'd100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_REM,
      ST_CHECK,
      ST_YEAR,
      ST_MONTH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic div;
      logic rem;
      logic check;
      logic year;
      logic month;
   } cmd_type;

   typedef struct packed {
      logic invalid;
      logic year_skip;
      logic month_skip;
   } status_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      begin
         case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
         endcase
         return len;
      end
   endfunction

endpackage

// ===== hw/rtl/cdad_ctrl.sv =====
// controller state machine for the date adder
// depends on cdad_pkg
`timescale 1ns / 1ps

module cdad_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  cdad_pkg::status_type status,
   output cdad_pkg::cmd_type    cmd
);
   import cdad_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV:   state_in = ST_REM;
         ST_REM:   state_in = ST_CHECK;
         ST_CHECK: state_in = status.invalid ? ST_DONE : ST_YEAR;
         ST_YEAR: begin
            if (!status.year_skip) begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (!status.month_skip) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DIV:   cmd.div   = 1'b1;
         ST_REM:   cmd.rem   = 1'b1;
         ST_CHECK: cmd.check = 1'b1;
         ST_YEAR:  cmd.year  = 1'b1;
         ST_MONTH: cmd.month = 1'b1;
         ST_DONE:  rsp_tvalid = 1'b1;
         default:  cmd = '0;
      endcase
   end

endmodule

// ===== hw/rtl/cdad_datapath.sv =====
// date registers, leap year tracking and the year and month step unit
// depends on cdad_pkg
`timescale 1ns / 1ps

module cdad_datapath (
   input  logic                          clock,
   input  logic [cdad_pkg::YEAR_W-1:0]   start_year,
   input  logic [cdad_pkg::MONTH_W-1:0]  start_month,
   input  logic [cdad_pkg::DAY_W-1:0]    start_day,
   input  logic [cdad_pkg::ADD_W-1:0]    days_to_add,
   input  cdad_pkg::cmd_type             cmd,
   output cdad_pkg::status_type          status,
   output logic [cdad_pkg::YEAR_W-1:0]   end_year,
   output logic [cdad_pkg::MONTH_W-1:0]  end_month,
   output logic [cdad_pkg::DAY_W-1:0]    end_day,
   output logic                          invalid_date
);
   import cdad_pkg::*;

   logic [YEAR_W-1:0]  year_ff;
   logic [MONTH_W-1:0] month_ff;
   logic [DAY_W-1:0]   day_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [QUOT_W-1:0]  quot_ff;
   // year mod 100 and (year div 100) mod 4
   logic [REM_W-1:0]   cent_ff;
   logic [1:0]         cq4_ff;
   logic               inv_ff;

   logic [YEAR_W+12:0] prod;
   logic [14:0]        quot_x100;
   logic               leap_cur;
   logic               leap_next;
   logic [YLEN_W-1:0]  year_len;
   logic [DAY_W-1:0]   mon_len;
   logic [REM_W-1:0]   cent_inc;
   logic [1:0]         cq4_inc;
   logic               bad_date;

   assign prod      = {13'd0, year_ff} * {{YEAR_W{1'b0}}, DIV100_MUL};
   assign quot_x100 = {7'd0, quot_ff} * {8'd0, CENTURY};

   assign leap_cur  = (year_ff[1:0] == 2'd0) && ((cent_ff != '0) || (cq4_ff == 2'd0));
   assign leap_next = (year_ff[1:0] == 2'd3) &&
                      ((cent_ff != CENTURY_LAST) || (cq4_ff == 2'd3));

   // from day one of a month, a whole year ahead crosses the next february after march
   assign year_len = YEAR_DAYS + {8'd0, (month_ff <= MONTH_FEB) ? leap_cur : leap_next};
   assign mon_len  = month_days(month_ff, leap_cur);

   assign cent_inc = (cent_ff == CENTURY_LAST) ? '0 : cent_ff + 7'd1;
   assign cq4_inc  = (cent_ff == CENTURY_LAST) ? cq4_ff + 2'd1 : cq4_ff;

   assign bad_date = (year_ff < YEAR_MIN) || (year_ff > YEAR_MAX) ||
                     (month_ff < MONTH_JAN) || (month_ff > MONTH_DEC) ||
                     (day_ff == '0) || (day_ff > mon_len);

   assign status.invalid    = bad_date;
   assign status.year_skip  = count_ff >= {{(CNT_W-YLEN_W){1'b0}}, year_len};
   assign status.month_skip = count_ff >= {{(CNT_W-DAY_W){1'b0}}, mon_len};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         year_ff  <= start_year;
         month_ff <= start_month;
         day_ff   <= start_day;
         count_ff <= {1'b0, days_to_add};
      end
      if (cmd.div) begin
         quot_ff <= prod[DIV100_SHIFT +: QUOT_W];
      end
      if (cmd.rem) begin
         cent_ff <= REM_W'({1'b0, year_ff} - quot_x100);
         cq4_ff  <= quot_ff[1:0];
      end
      if (cmd.check) begin
         inv_ff <= bad_date;
         if (!bad_date) begin
            // walk from day one of the month
            count_ff <= count_ff + {{(CNT_W-DAY_W){1'b0}}, day_ff} - CNT_W'(1);
         end
      end
      if (cmd.year && status.year_skip) begin
         count_ff <= count_ff - {{(CNT_W-YLEN_W){1'b0}}, year_len};
         year_ff  <= year_ff + YEAR_W'(1);
         cent_ff  <= cent_inc;
         cq4_ff   <= cq4_inc;
      end
      if (cmd.month) begin
         if (status.month_skip) begin
            count_ff <= count_ff - {{(CNT_W-DAY_W){1'b0}}, mon_len};
            if (month_ff == MONTH_DEC) begin
               month_ff <= MONTH_JAN;
               year_ff  <= year_ff + YEAR_W'(1);
               cent_ff  <= cent_inc;
               cq4_ff   <= cq4_inc;
            end else begin
               month_ff <= month_ff + MONTH_W'(1);
            end
         end else begin
            day_ff <= count_ff[DAY_W-1:0] + DAY_W'(1);
         end
      end
   end

   assign end_year     = year_ff;
   assign end_month    = month_ff;
   assign end_day      = day_ff;
   assign invalid_date = inv_ff;

endmodule

// ===== hw/rtl/calendar_date_add_days_top.sv =====
// an item goes through divide, remainder and check, then one year step per whole year skipped (up to about 2870)
// and one month step per month walked (up to 11); an invalid date goes from check to the result
// throughput: one item at a time, set by the single year and month step unit
// reset: synchronous active high, returns the controller to idle with no result pending
// depends on cdad_pkg, cdad_ctrl and cdad_datapath
`timescale 1ns / 1ps

module calendar_date_add_days_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // start_year[13:0], start_month[17:14], start_day[22:18], days_to_add[42:23], zero pad
   input  logic [cdad_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // end_year[13:0], end_month[17:14], end_day[22:18], zero pad
   output logic [cdad_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // invalid_date[0]
   output logic                                rsp_tuser
);
   import cdad_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic [YEAR_W-1:0]  end_year;
   logic [MONTH_W-1:0] end_month;
   logic [DAY_W-1:0]   end_day;

   cdad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cdad_datapath u_datapath (
      .clock        (clock),
      .start_year   (req_tdata[13:0]),
      .start_month  (req_tdata[17:14]),
      .start_day    (req_tdata[22:18]),
      .days_to_add  (req_tdata[42:23]),
      .cmd          (cmd),
      .status       (status),
      .end_year     (end_year),
      .end_month    (end_month),
      .end_day      (end_day),
      .invalid_date (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, end_day, end_month, end_year};

endmodule

// ===== bench/calendar_date_add_days_top_test.sv =====
// testbench for calendar_date_add_days_top: directed and random dates, checked against
// a calendar predictor built in; depends on cdad_pkg and the rtl under hw/rtl
`timescale 1ns / 1ps

module calendar_date_add_days_top_test;

   import cdad_pkg::*;

   localparam int QUIET_LIMIT = 20000;
   localparam int LONG_HOLD   = 400;

   typedef struct {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic               invalid;
   } date_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   date_result_type expected_dates[$];
   int  items_sent      = 0;
   int  bad_starts_sent = 0;
   int  results_seen    = 0;
   int  mismatch_count  = 0;
   int  quiet_cycles    = 0;
   bit  sender_idle     = 1'b1;
   bit  receiver_idle   = 1'b1;
   bit  hold_request    = 1'b0;

   calendar_date_add_days_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit is_leap(input longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int month_length(input longint y, input longint m);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return is_leap(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic date_result_type add_days_to_date(input logic [YEAR_W-1:0] y,
                                                        input logic [MONTH_W-1:0] m,
                                                        input logic [DAY_W-1:0] d,
                                                        input logic [ADD_W-1:0] n);
      date_result_type res;
      longint march_year, cycle, year_in_cycle, month_idx, day_in_year;
      longint day_in_cycle, day_count, out_month;
      begin
         if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1 ||
             longint'(d) > longint'(month_length(longint'(y), longint'(m)))) begin
            res.year    = y;
            res.month   = m;
            res.day     = d;
            res.invalid = 1'b1;
            return res;
         end
         // days since 0000-03-01, with the year taken to start in March
         march_year    = longint'(y) - ((m <= 2) ? 1 : 0);
         cycle         = march_year / 400;
         year_in_cycle = march_year - cycle * 400;
         month_idx     = (m > 2) ? longint'(m) - 3 : longint'(m) + 9;
         day_in_year   = (153 * month_idx + 2) / 5 + longint'(d) - 1;
         day_in_cycle  = year_in_cycle * 365 + year_in_cycle / 4 - year_in_cycle / 100
                         + day_in_year;
         day_count     = cycle * 146097 + day_in_cycle + longint'(n);
         // and back again
         cycle         = day_count / 146097;
         day_in_cycle  = day_count - cycle * 146097;
         year_in_cycle = (day_in_cycle - day_in_cycle / 1460 + day_in_cycle / 36524
                          - day_in_cycle / 146096) / 365;
         day_in_year   = day_in_cycle - (365 * year_in_cycle + year_in_cycle / 4
                                         - year_in_cycle / 100);
         month_idx     = (5 * day_in_year + 2) / 153;
         out_month     = (month_idx < 10) ? month_idx + 3 : month_idx - 9;
         res.day       = DAY_W'(day_in_year - (153 * month_idx + 2) / 5 + 1);
         res.month     = MONTH_W'(out_month);
         res.year      = YEAR_W'(year_in_cycle + cycle * 400 + ((out_month <= 2) ? 1 : 0));
         res.invalid   = 1'b0;
         return res;
      end
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                            input logic [DAY_W-1:0] d, input logic [ADD_W-1:0] n);
      date_result_type want;
      begin
         want = add_days_to_date(y, m, d, n);
         if (sender_idle && $urandom_range(0, 4) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {5'd0, n, d, m, y};
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         expected_dates.push_back(want);
         items_sent++;
         if (want.invalid) bad_starts_sent++;
      end
   endtask

   // sender stops and waits for every pending result
   task automatic wait_for_results;
      begin
         req_tvalid <= 1'b0;
         while (expected_dates.size() != 0) @(posedge clock);
      end
   endtask

   task automatic pick_valid_start(output logic [YEAR_W-1:0] y,
                                   output logic [MONTH_W-1:0] m,
                                   output logic [DAY_W-1:0] d);
      begin
         y = YEAR_W'($urandom_range(1, 9999));
         m = MONTH_W'($urandom_range(1, 12));
         // lean on month ends, where the carries happen
         if ($urandom_range(0, 3) == 0)
            d = DAY_W'(month_length(longint'(y), longint'(m)));
         else
            d = DAY_W'($urandom_range(1, month_length(longint'(y), longint'(m))));
      end
   endtask

   function automatic logic [ADD_W-1:0] pick_day_count;
      int pick;
      begin
         pick = $urandom_range(0, 9);
         // large counts make the adder step through each whole year in turn, so keep them rare
         if (pick < 6) return ADD_W'($urandom_range(0, 400));
         if (pick < 9) return ADD_W'($urandom_range(0, 40000));
         return ADD_W'($urandom_range(0, (1 << ADD_W) - 1));
      end
   endfunction

   // ---------------------------------------------------------------- receiving

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      begin
         $display("mismatch in %s: got %0d, want %0d (result %0d)", what, got, want,
                  results_seen);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_result
      date_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_dates.size() == 0) begin
            report_mismatch("result with nothing pending", longint'(rsp_tdata), 64'd0);
         end else begin
            want = expected_dates.pop_front();
            if (rsp_tdata[YEAR_W-1:0] !== want.year)
               report_mismatch("end_year", longint'(rsp_tdata[YEAR_W-1:0]),
                               longint'(want.year));
            if (rsp_tdata[YEAR_W+MONTH_W-1:YEAR_W] !== want.month)
               report_mismatch("end_month", longint'(rsp_tdata[YEAR_W+MONTH_W-1:YEAR_W]),
                               longint'(want.month));
            if (rsp_tdata[YEAR_W+MONTH_W+DAY_W-1:YEAR_W+MONTH_W] !== want.day)
               report_mismatch("end_day",
                               longint'(rsp_tdata[YEAR_W+MONTH_W+DAY_W-1:YEAR_W+MONTH_W]),
                               longint'(want.day));
            if (rsp_tdata[RSP_DATA_W-1:YEAR_W+MONTH_W+DAY_W] !== '0)
               report_mismatch("tdata pad",
                               longint'(rsp_tdata[RSP_DATA_W-1:YEAR_W+MONTH_W+DAY_W]), 64'd0);
            if (rsp_tuser !== want.invalid)
               report_mismatch("invalid_date", longint'(rsp_tuser), longint'(want.invalid));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("calendar_date_add_days_top verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_directed_dates;
      begin
         send_date(14'd1, 4'd1, 5'd1, 20'd0);
         send_date(14'd2024, 4'd2, 5'd28, 20'd1);       // into a leap day
         send_date(14'd2023, 4'd2, 5'd28, 20'd1);       // common year skips to march
         send_date(14'd1900, 4'd2, 5'd28, 20'd1);       // century, not leap
         send_date(14'd2000, 4'd2, 5'd28, 20'd1);       // fourth century, leap
         send_date(14'd2000, 4'd2, 5'd29, 20'd0);
         send_date(14'd1999, 4'd12, 5'd31, 20'd1);      // year wrap
         send_date(14'd2020, 4'd1, 5'd31, 20'd30);
         send_date(14'd2020, 4'd3, 5'd15, 20'd365);
         send_date(14'd2019, 4'd6, 5'd30, 20'd1000);
         send_date(14'd9999, 4'd12, 5'd31, 20'hFFFFF);  // largest possible sum
         send_date(14'd1, 4'd1, 5'd1, 20'hFFFFF);
         send_date(14'd2023, 4'd2, 5'd29, 20'd5);       // leap day in a common year
         send_date(14'd1900, 4'd2, 5'd29, 20'd7);
         send_date(14'd0, 4'd5, 5'd5, 20'd10);          // year below range
         send_date(14'd10000, 4'd1, 5'd1, 20'd10);      // year above range
         send_date(14'h3FFF, 4'hF, 5'h1F, 20'hFFFFF);
         send_date(14'd2020, 4'd0, 5'd1, 20'd1);        // month zero
         send_date(14'd2020, 4'd13, 5'd1, 20'd1);
         send_date(14'd2020, 4'd4, 5'd31, 20'd1);       // day past a 30 day month
         send_date(14'd2020, 4'd1, 5'd0, 20'd1);        // day zero
         wait_for_results;
      end
   endtask

   task automatic test_random_valid_dates(input int count);
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      begin
         repeat (count) begin
            pick_valid_start(y, m, d);
            send_date(y, m, d, pick_day_count());
         end
         wait_for_results;
      end
   endtask

   task automatic test_malformed_dates(input int count);
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      int                 len;
      begin
         repeat (count) begin
            pick_valid_start(y, m, d);
            case ($urandom_range(0, 5))
               0: y = ($urandom_range(0, 1) == 0) ? '0 : YEAR_W'($urandom_range(10000, 16383));
               1: m = ($urandom_range(0, 1) == 0) ? '0 : MONTH_W'($urandom_range(13, 15));
               2: d = '0;
               3: begin
                  len = month_length(longint'(y), longint'(m));
                  d = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : '0;
               end
               4: begin
                  // leap day in a year that has none
                  y = ($urandom_range(0, 1) == 0) ? YEAR_W'(100 * $urandom_range(1, 99))
                                                  : YEAR_W'(4 * $urandom_range(0, 2499) + 1);
                  if (y % 400 == 0) y = y + YEAR_W'(100);
                  m = 4'd2;
                  d = 5'd29;
               end
               default: begin
                  y = YEAR_W'($urandom_range(0, (1 << YEAR_W) - 1));
                  m = MONTH_W'($urandom_range(0, (1 << MONTH_W) - 1));
                  d = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
               end
            endcase
            send_date(y, m, d, ADD_W'($urandom_range(0, (1 << ADD_W) - 1)));
         end
         wait_for_results;
      end
   endtask

   // receiver stalls long while items keep coming, so the input has to stall too
   task automatic test_output_backpressure;
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      begin
         hold_request = 1'b1;
         repeat (6) begin
            pick_valid_start(y, m, d);
            send_date(y, m, d, ADD_W'($urandom_range(0, 60)));
         end
         wait_for_results;
      end
   endtask

   task automatic test_steady_stream(input int count);
      begin
         sender_idle   = 1'b0;
         receiver_idle = 1'b0;
         test_random_valid_dates(count);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_dates;
      test_random_valid_dates(140);
      test_malformed_dates(30);
      test_output_backpressure;
      test_steady_stream(20);
      repeat (50) @(posedge clock);
      if (expected_dates.size() != 0)
         report_mismatch("results never delivered", 64'd0, longint'(expected_dates.size()));
      $display("sent %0d items (%0d with a bad start date), checked %0d results",
               items_sent, bad_starts_sent, results_seen);
      $display("ran leap and century rules, year wrap, largest counts and long output stalls");
      if (mismatch_count == 0) begin
         $display("calendar_date_add_days_top verification clean");
      end else begin
         $display("calendar_date_add_days_top verification failed");
      end
      $finish;
   end

endmodule
